### rtl/core/pvhc_pkg.sv
// pvhc_pkg: shared types, codes and constants of the pressure valve controller
// used by pvhc_scale, pvhc_mode and pressure_valve_hysteresis_controller

package pvhc_pkg;

    // valve controller modes
    typedef enum logic [1:0] {
        VALVE_SAFE = 2'd0,
        VALVE_FILL = 2'd1,
        VALVE_HOLD = 2'd2,
        VALVE_VENT = 2'd3
    } mode_t;

    // result of one mode machine step
    typedef struct packed {
        mode_t mode;
        logic  inlet_open;
        logic  outlet_open;
    } mode_res_t;

    // operator commands
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b1;

    localparam int unsigned SETPOINT_W  = 9;
    localparam int unsigned TOLERANCE_W = 8;
    localparam logic [SETPOINT_W-1:0]  SETPOINT_RESET  = 9'd100;
    localparam logic [TOLERANCE_W-1:0] TOLERANCE_RESET = 8'd5;

    localparam int unsigned FRAC_BITS_DEFAULT = 7;

    // sensor scaling: 300 bar over 3475 codes reduces to 12 / 139
    localparam int unsigned ADC_W          = 12;
    localparam int unsigned ADC_ZERO_CODE  = 620;
    localparam int unsigned ADC_SPAN_CODES = 3475;
    localparam int unsigned FULL_SCALE_BAR = 300;
    localparam int unsigned SCALE_NUM      = 12;
    localparam int unsigned SCALE_DEN      = 139;
    localparam int unsigned SCALE_DEN_BITS = 8;

    localparam int unsigned DRIVE_W = 16;
    localparam int unsigned PRESSURE_OUT_W = 16;
    localparam logic [DRIVE_W-1:0] DRIVE_OPEN   = 16'hFFFF;
    localparam logic [DRIVE_W-1:0] DRIVE_CLOSED = 16'h0000;

endpackage

### rtl/core/pvhc_scale.sv
// pvhc_scale: converts a raw sensor conversion to fixed point pressure
// depends on pvhc_pkg

module pvhc_scale #(
    parameter int unsigned PRESSURE_FRAC_BITS = pvhc_pkg::FRAC_BITS_DEFAULT,
    parameter int unsigned QW = $clog2((pvhc_pkg::FULL_SCALE_BAR << PRESSURE_FRAC_BITS) + 1)
) (
    input  logic                         sample_valid,
    input  logic [pvhc_pkg::ADC_W-1:0]   adc_sample,
    output logic [QW-1:0]                pressure_q
);

    localparam longint unsigned K_MULT = longint'(pvhc_pkg::SCALE_NUM) << PRESSURE_FRAC_BITS;
    localparam longint unsigned N_MAX  = longint'(pvhc_pkg::ADC_SPAN_CODES) * K_MULT;
    localparam int unsigned     NW     = $clog2(N_MAX + 1);
    localparam int unsigned     SHIFT  = NW + pvhc_pkg::SCALE_DEN_BITS;
    localparam longint unsigned RECIP  =
        ((longint'(1) << SHIFT) + pvhc_pkg::SCALE_DEN - 1) / pvhc_pkg::SCALE_DEN;
    localparam int unsigned     RW     = NW + 1;
    localparam int unsigned     PW     = NW + RW;
    localparam longint unsigned TOP_Q  = longint'(pvhc_pkg::FULL_SCALE_BAR) << PRESSURE_FRAC_BITS;

    logic                         above_zero;
    logic [pvhc_pkg::ADC_W-1:0]   span_code;
    logic [NW-1:0]                numer;
    logic [PW-1:0]                prod;
    logic [QW-1:0]                quo;

    // exact floor division by the scale denominator through a rounded-up reciprocal
    assign above_zero = sample_valid &&
                        (adc_sample > pvhc_pkg::ADC_W'(pvhc_pkg::ADC_ZERO_CODE));
    assign span_code  = adc_sample - pvhc_pkg::ADC_W'(pvhc_pkg::ADC_ZERO_CODE);
    assign numer      = NW'(span_code) * NW'(K_MULT);
    assign prod       = PW'(numer) * PW'(RECIP);
    assign quo        = QW'(prod >> SHIFT);

    always_comb begin
        if (!above_zero) begin
            pressure_q = '0;
        end else if (quo > QW'(TOP_Q)) begin
            pressure_q = QW'(TOP_Q);
        end else begin
            pressure_q = quo;
        end
    end

endmodule

### rtl/core/pvhc_mode.sv
// pvhc_mode: four-mode hysteresis machine holding the valve mode
// depends on pvhc_pkg

module pvhc_mode #(
    parameter int unsigned PRESSURE_FRAC_BITS = pvhc_pkg::FRAC_BITS_DEFAULT,
    parameter int unsigned QW = $clog2((pvhc_pkg::FULL_SCALE_BAR << PRESSURE_FRAC_BITS) + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic [1:0]                          operation,
    input  logic [QW-1:0]                       pressure_q,
    input  logic [pvhc_pkg::SETPOINT_W-1:0]     setpoint_bar,
    input  logic [pvhc_pkg::TOLERANCE_W-1:0]    tolerance_bar,
    output pvhc_pkg::mode_res_t                 res
);

    // setpoint plus twice the widest tolerance stays below 1024 whole bar
    localparam int unsigned LW = PRESSURE_FRAC_BITS + 11;

    pvhc_pkg::mode_t mode_reg;
    pvhc_pkg::mode_t mode_cmd;
    pvhc_pkg::mode_t mode_next;

    logic [LW-1:0] q_x;
    logic [LW-1:0] sp_x;
    logic [LW-1:0] tol_x;
    logic          at_or_above_sp;
    logic          below_band;
    logic          above_band;
    logic          at_or_below_sp;

    assign q_x   = LW'(pressure_q);
    assign sp_x  = LW'(setpoint_bar) << PRESSURE_FRAC_BITS;
    assign tol_x = LW'(tolerance_bar) << PRESSURE_FRAC_BITS;

    assign at_or_above_sp = q_x >= sp_x;
    assign below_band     = (q_x + tol_x) < sp_x;
    assign above_band     = q_x > (sp_x + (tol_x << 1));
    assign at_or_below_sp = q_x <= sp_x;

    // operator command
    always_comb begin
        case (operation)
            pvhc_pkg::OP_START: begin
                mode_cmd = (mode_reg == pvhc_pkg::VALVE_SAFE) ? pvhc_pkg::VALVE_FILL
                                                              : mode_reg;
            end
            pvhc_pkg::OP_STOP: begin
                mode_cmd = pvhc_pkg::VALVE_SAFE;
            end
            default: begin
                mode_cmd = mode_reg;
            end
        endcase
    end

    // next mode
    always_comb begin
        case (mode_cmd)
            pvhc_pkg::VALVE_FILL: begin
                mode_next = at_or_above_sp ? pvhc_pkg::VALVE_HOLD : pvhc_pkg::VALVE_FILL;
            end
            pvhc_pkg::VALVE_HOLD: begin
                if (above_band) begin
                    mode_next = pvhc_pkg::VALVE_VENT;
                end else if (below_band) begin
                    mode_next = pvhc_pkg::VALVE_FILL;
                end else begin
                    mode_next = pvhc_pkg::VALVE_HOLD;
                end
            end
            pvhc_pkg::VALVE_VENT: begin
                mode_next = at_or_below_sp ? pvhc_pkg::VALVE_HOLD
                                           : pvhc_pkg::VALVE_VENT;
            end
            default: begin
                mode_next = pvhc_pkg::VALVE_SAFE;
            end
        endcase
    end

    // drives follow the mode before the transition
    always_comb begin
        res.mode        = mode_next;
        res.inlet_open  = (mode_cmd == pvhc_pkg::VALVE_FILL);
        res.outlet_open = (mode_cmd == pvhc_pkg::VALVE_VENT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= pvhc_pkg::VALVE_SAFE;
        end else if (advance) begin
            mode_reg <= mode_next;
        end
    end

endmodule

### rtl/core/pressure_valve_hysteresis_controller.sv
// pressure_valve_hysteresis_controller: top level of the valve controller
// depends on pvhc_pkg, pvhc_scale and pvhc_mode
//
// Usage: one control tick per s_ transfer carries sample_valid, a 12-bit
// sensor conversion and an operator command (none, start, stop). Each tick
// returns exactly one m_ transfer with the pressure in bar times
// 2^PRESSURE_FRAC_BITS, the new valve mode and the inlet and outlet drives.
// Setpoint and tolerance are written over the cfg_ port, index 0 and 1;
// the user must write them only while no tick is in flight, since the
// block itself does not enforce it. cfg_ready is always high. The
// sensor scaling (one reciprocal multiplier) fills the input stage
// register on an s_ transfer, the mode machine fills the result register,
// which drives m_valid. Throughput is one tick per cycle without a stall.
// A stalled m_ready holds the result register; the input stage still
// takes one more tick, then s_ready drops until the result is taken.
// Synchronous reset clears both stages, puts the valve in safe mode and
// loads setpoint 100 bar and tolerance 5 bar.

module pressure_valve_hysteresis_controller #(
    parameter int unsigned PRESSURE_FRAC_BITS = pvhc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_sample_valid,
    input  logic [pvhc_pkg::ADC_W-1:0]          s_adc_sample,
    input  logic [1:0]                          s_operation,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pvhc_pkg::PRESSURE_OUT_W-1:0] m_pressure_q,
    output logic [1:0]                          m_mode_out,
    output logic [pvhc_pkg::DRIVE_W-1:0]        m_inlet_drive,
    output logic [pvhc_pkg::DRIVE_W-1:0]        m_outlet_drive,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pvhc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pvhc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned QW =
        $clog2((pvhc_pkg::FULL_SCALE_BAR << PRESSURE_FRAC_BITS) + 1);

    logic                                 s_fire;
    logic                                 adv;
    logic [QW-1:0]                        scaled_q;
    pvhc_pkg::mode_res_t                  mode_res;

    logic                                 p1_valid_reg;
    logic [QW-1:0]                        p1_q_reg;
    logic [1:0]                           p1_op_reg;

    logic                                 m_valid_reg;
    logic [pvhc_pkg::PRESSURE_OUT_W-1:0]  m_pressure_q_reg;
    logic [1:0]                           m_mode_reg;
    logic [pvhc_pkg::DRIVE_W-1:0]         m_inlet_reg;
    logic [pvhc_pkg::DRIVE_W-1:0]         m_outlet_reg;

    logic [pvhc_pkg::SETPOINT_W-1:0]      setpoint_reg;
    logic [pvhc_pkg::TOLERANCE_W-1:0]     tolerance_reg;

    assign adv       = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !p1_valid_reg || adv;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid        = m_valid_reg;
    assign m_pressure_q   = m_pressure_q_reg;
    assign m_mode_out     = m_mode_reg;
    assign m_inlet_drive  = m_inlet_reg;
    assign m_outlet_drive = m_outlet_reg;

    pvhc_scale #(
        .PRESSURE_FRAC_BITS (PRESSURE_FRAC_BITS),
        .QW                 (QW)
    ) u_scale (
        .sample_valid (s_sample_valid),
        .adc_sample   (s_adc_sample),
        .pressure_q   (scaled_q)
    );

    pvhc_mode #(
        .PRESSURE_FRAC_BITS (PRESSURE_FRAC_BITS),
        .QW                 (QW)
    ) u_mode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (adv),
        .operation     (p1_op_reg),
        .pressure_q    (p1_q_reg),
        .setpoint_bar  (setpoint_reg),
        .tolerance_bar (tolerance_reg),
        .res           (mode_res)
    );

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            setpoint_reg  <= pvhc_pkg::SETPOINT_RESET;
            tolerance_reg <= pvhc_pkg::TOLERANCE_RESET;
        end else begin
            if (s_fire) begin
                p1_valid_reg <= 1'b1;
            end else if (adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    pvhc_pkg::CFG_SETPOINT: begin
                        setpoint_reg <= cfg_data[pvhc_pkg::SETPOINT_W-1:0];
                    end
                    pvhc_pkg::CFG_TOLERANCE: begin
                        tolerance_reg <= cfg_data[pvhc_pkg::TOLERANCE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_q_reg  <= scaled_q;
            p1_op_reg <= s_operation;
        end
        if (adv) begin
            m_pressure_q_reg <= pvhc_pkg::PRESSURE_OUT_W'(p1_q_reg);
            m_mode_reg       <= mode_res.mode;
            m_inlet_reg      <= mode_res.inlet_open ? pvhc_pkg::DRIVE_OPEN
                                                    : pvhc_pkg::DRIVE_CLOSED;
            m_outlet_reg     <= mode_res.outlet_open ? pvhc_pkg::DRIVE_OPEN
                                                     : pvhc_pkg::DRIVE_CLOSED;
        end
    end

    // both valves never open together
    a_valves_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_inlet_drive != pvhc_pkg::DRIVE_CLOSED &&
                      m_outlet_drive != pvhc_pkg::DRIVE_CLOSED))
        else $error("inlet and outlet open together");

    // an open inlet leaves the machine filling or holding
    a_inlet_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_inlet_drive == pvhc_pkg::DRIVE_OPEN) |->
            (m_mode_out == pvhc_pkg::VALVE_FILL || m_mode_out == pvhc_pkg::VALVE_HOLD))
        else $error("inlet open with unexpected next mode");

    // an open outlet leaves the machine releasing or holding
    a_outlet_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_outlet_drive == pvhc_pkg::DRIVE_OPEN) |->
            (m_mode_out == pvhc_pkg::VALVE_VENT || m_mode_out == pvhc_pkg::VALVE_HOLD))
        else $error("outlet open with unexpected next mode");

    // a stop command always lands in safe mode with both valves closed
    a_stop_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && p1_op_reg == pvhc_pkg::OP_STOP) |=>
            (m_valid && m_mode_out == pvhc_pkg::VALVE_SAFE &&
             m_inlet_drive == pvhc_pkg::DRIVE_CLOSED &&
             m_outlet_drive == pvhc_pkg::DRIVE_CLOSED))
        else $error("stop command did not reach safe mode");

endmodule
